/* hw/rtl/wfha_pkg.sv */
// Package for the worst-fit heap allocator: action codes, header constants
// and the arena control struct. No dependencies.
package wfha_pkg;

   localparam int HEAP_BYTES_DEF = 4096;
   localparam int WORD_W         = 13;
   localparam int HDR_BYTES      = 16;
   localparam int WORD_BYTES     = 8;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

/* hw/rtl/wfha_arena.sv */
// Arena word store with one write and one registered read port, plus the
// clearing sweep after reset. Depends on wfha_pkg.
module wfha_arena
   import wfha_pkg::*;
#(
   parameter int WORDS = HEAP_BYTES_DEF / WORD_BYTES,
   localparam int IW   = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_ctl_type       ctl,
   input  logic [IW-1:0]     rd_idx,
   input  logic [IW-1:0]     wr_idx,
   input  logic [WORD_W-1:0] wr_data,
   output logic [WORD_W-1:0] rd_data,
   output logic              clear_busy
);

   logic [WORD_W-1:0] mem [WORDS];
   logic [IW-1:0]     clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              w_en;
   logic [IW-1:0]     w_idx;
   logic [WORD_W-1:0] w_data;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == IW'(WORDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign w_en   = busy_ff | ctl.wr_en;
   assign w_idx  = busy_ff ? clr_ff : wr_idx;
   assign w_data = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (w_en) begin
         mem[w_idx] <= w_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

/* hw/rtl/wfha_seq.sv */
// Sequencer for allocate, free and release: walks block headers through the
// arena port one word at a time. Depends on wfha_pkg.
module wfha_seq
   import wfha_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF,
   localparam int WORDS     = HEAP_BYTES / WORD_BYTES,
   localparam int IW        = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        action,
   input  logic [12:0]       request_bytes,
   input  logic [12:0]       block_address,
   input  logic              out_free,
   input  logic [WORD_W-1:0] rd_data,
   output logic              idle,
   output logic              done,
   output logic [12:0]       res_payload,
   output logic              res_ok,
   output mem_ctl_type       ctl,
   output logic [IW-1:0]     rd_idx,
   output logic [IW-1:0]     wr_idx,
   output logic [WORD_W-1:0] wr_data
);

   localparam int PW = $clog2(HEAP_BYTES + 16416) + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_WCHK   = 4'd1;
   localparam logic [3:0] S_WOCC   = 4'd2;
   localparam logic [3:0] S_WSZ    = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_SPL1   = 4'd5;
   localparam logic [3:0] S_SPL2   = 4'd6;
   localparam logic [3:0] S_MARK   = 4'd7;
   localparam logic [3:0] S_FRD    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [12:0]       req_ff, req_in;
   logic [PW-1:0]     hdr_ff, hdr_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     best_ff, best_in;
   logic [WORD_W-1:0] bsize_ff, bsize_in;
   logic [WORD_W-1:0] occ_ff, occ_in;
   logic [PW-1:0]     heap_end_ff, heap_end_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [12:0]       pay_ff, pay_in;
   logic              ok_ff, ok_in;

   logic [WORD_W-1:0] rd_word;
   logic [PW-1:0]     free_hdr;
   logic [PW-1:0]     new_end;
   logic [PW-1:0]     req_hdr;
   logic [PW-1:0]     rd_addr;
   logic [PW-1:0]     wr_addr;

   function automatic logic in_arena(input logic [PW-1:0] b);
      in_arena = (b >> 3) < PW'(WORDS);
   endfunction

   assign rd_word  = rd_ok_ff ? rd_data : '0;
   assign free_hdr = PW'(block_address) - PW'(HDR_BYTES);
   assign req_hdr  = PW'(req_ff) + PW'(HDR_BYTES);
   assign new_end  = pos_ff + req_hdr;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      hdr_in      = hdr_ff;
      pos_in      = pos_ff;
      best_in     = best_ff;
      bsize_in    = bsize_ff;
      occ_in      = occ_ff;
      heap_end_in = heap_end_ff;
      rd_ok_in    = rd_ok_ff;
      pay_in      = pay_ff;
      ok_in       = ok_ff;
      ctl         = '0;
      rd_addr     = pos_ff;
      wr_addr     = best_ff;
      wr_data     = '0;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = request_bytes;
               pay_in   = '0;
               ok_in    = 1'b0;
               state_in = S_DONE;
               unique case (action)
                  ACT_ALLOC: begin
                     if (request_bytes[2:0] == 3'd0) begin
                        pos_in   = '0;
                        best_in  = '0;
                        bsize_in = '0;
                        state_in = S_WCHK;
                     end
                  end
                  ACT_FREE: begin
                     if (block_address >= 13'(HDR_BYTES) && block_address[2:0] == 3'd0
                         && free_hdr < heap_end_ff) begin
                        hdr_in    = free_hdr;
                        rd_addr   = free_hdr;
                        ctl.rd_en = 1'b1;
                        rd_ok_in  = in_arena(free_hdr);
                        state_in  = S_FRD;
                     end
                  end
                  ACT_RELEASE: begin
                     heap_end_in = '0;
                     ok_in       = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_WCHK: begin
            if (pos_ff < heap_end_ff) begin
               rd_addr   = pos_ff;
               ctl.rd_en = 1'b1;
               rd_ok_in  = in_arena(pos_ff);
               state_in  = S_WOCC;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_WOCC: begin
            occ_in    = rd_word;
            rd_addr   = pos_ff + PW'(WORD_BYTES);
            ctl.rd_en = 1'b1;
            rd_ok_in  = in_arena(rd_addr);
            state_in  = S_WSZ;
         end
         S_WSZ: begin
            if (occ_ff == '0 && rd_word >= req_ff && rd_word > bsize_ff) begin
               best_in  = pos_ff;
               bsize_in = rd_word;
            end
            pos_in   = pos_ff + PW'(rd_word) + PW'(HDR_BYTES);
            state_in = S_WCHK;
         end
         S_DECIDE: begin
            if (bsize_ff == '0) begin
               if (new_end > PW'(HEAP_BYTES)) begin
                  state_in = S_DONE;
               end else begin
                  heap_end_in = new_end;
                  best_in     = pos_ff;
                  wr_addr     = pos_ff + PW'(WORD_BYTES);
                  wr_data     = req_ff;
                  ctl.wr_en   = in_arena(wr_addr);
                  state_in    = S_MARK;
               end
            end else if (PW'(bsize_ff) > req_hdr) begin
               wr_addr   = best_ff + PW'(WORD_BYTES);
               wr_data   = req_ff;
               ctl.wr_en = in_arena(wr_addr);
               state_in  = S_SPL1;
            end else begin
               state_in = S_MARK;
            end
         end
         S_SPL1: begin
            wr_addr   = best_ff + req_hdr;
            wr_data   = '0;
            ctl.wr_en = in_arena(wr_addr);
            state_in  = S_SPL2;
         end
         S_SPL2: begin
            wr_addr   = best_ff + req_hdr + PW'(WORD_BYTES);
            wr_data   = WORD_W'(PW'(bsize_ff) - req_hdr);
            ctl.wr_en = in_arena(wr_addr);
            state_in  = S_MARK;
         end
         S_MARK: begin
            wr_addr   = best_ff;
            wr_data   = WORD_W'(1);
            ctl.wr_en = in_arena(best_ff);
            pay_in    = 13'(best_ff + PW'(HDR_BYTES));
            ok_in     = 1'b1;
            state_in  = S_DONE;
         end
         S_FRD: begin
            if (rd_word != '0) begin
               wr_addr   = hdr_ff;
               wr_data   = '0;
               ctl.wr_en = in_arena(hdr_ff);
               ok_in     = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         heap_end_ff <= '0;
      end else begin
         state_ff    <= state_in;
         heap_end_ff <= heap_end_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      hdr_ff   <= hdr_in;
      pos_ff   <= pos_in;
      best_ff  <= best_in;
      bsize_ff <= bsize_in;
      occ_ff   <= occ_in;
      rd_ok_ff <= rd_ok_in;
      pay_ff   <= pay_in;
      ok_ff    <= ok_in;
   end

   assign idle        = (state_ff == S_IDLE);
   assign res_payload = pay_ff;
   assign res_ok      = ok_ff;
   assign rd_idx      = rd_addr[IW+2:3];
   assign wr_idx      = wr_addr[IW+2:3];

endmodule

/* hw/rtl/worst_fit_heap_allocator_unit.sv */
// Top level of the worst-fit heap allocator: stream ports, result register
// and assertions. Depends on wfha_pkg, wfha_arena and wfha_seq.
//
//   channel  direction  tdata                      tuser
//   req      in         request_bytes, block_addr  action
//   rsp      out        payload_address            ok
//
// Allocate walks each block header (two reads through the one read port, one
// compare), with accept, end check, decide, split and mark around the walk.
// A free reads the header and clears it if set; a release or rejected request goes to done.
// After reset the arena is swept to zero word by word, with req_tready low.
// A result waits in the rsp register; the sequencer holds its last state while
// that register is full, and the next transaction waits until it has left.
module worst_fit_heap_allocator_unit
   import wfha_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_bytes[12:0], block_address[25:13], zero
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_address[12:0], zero
   output logic        rsp_tuser    // ok[0]
);

   localparam int WORDS = HEAP_BYTES / WORD_BYTES;
   localparam int IW    = $clog2(WORDS);

   mem_ctl_type       ctl;
   logic [IW-1:0]     rd_idx;
   logic [IW-1:0]     wr_idx;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;
   logic              clear_busy;
   logic              seq_idle;
   logic              seq_done;
   logic [12:0]       res_payload;
   logic              res_ok;
   logic              start;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [12:0]       rsp_pay_ff, rsp_pay_in;
   logic              rsp_ok_ff, rsp_ok_in;

   wfha_arena #(
      .WORDS(WORDS)
   ) u_arena (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_idx     (rd_idx),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   wfha_seq #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .action        (req_tuser),
      .request_bytes (req_tdata[12:0]),
      .block_address (req_tdata[25:13]),
      .out_free      (out_free),
      .rd_data       (rd_data),
      .idle          (seq_idle),
      .done          (seq_done),
      .res_payload   (res_payload),
      .res_ok        (res_ok),
      .ctl           (ctl),
      .rd_idx        (rd_idx),
      .wr_idx        (wr_idx),
      .wr_data       (wr_data)
   );

   assign req_tready = seq_idle & ~clear_busy;
   assign start      = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pay_in   = rsp_pay_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = res_payload;
         rsp_ok_in    = res_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pay_ff <= rsp_pay_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pay_ff};
   assign rsp_tuser  = rsp_ok_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("transaction accepted during arena sweep");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 16'd0))
      else $error("failed result carries a nonzero payload address");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending one");

endmodule
